// ===== hdl/utf8_to_utf16_decoder_assert.svh =====
// Assertion macros for the UTF-8 to UTF-16 decoder checker.
// Expects clk and arst_n in the scope of each use.
`ifndef UTF8_TO_UTF16_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_ASSERT_SVH

// Holds whenever reset is released.
`define U8U16_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define U8U16_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/u8u16_pkg.sv =====
// Types and constants shared by the UTF-8 to UTF-16 decoder.
// No dependencies.
package u8u16_pkg;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [15:0] word_out;
		logic        last_of_run;
		logic [15:0] words_so_far;
	} out_item_t;

	// partial sequence kept between bytes
	typedef struct packed {
		logic [20:0] codepoint;
		logic [1:0]  remaining;
	} dec_state_t;

	// all the words one byte produces
	typedef struct packed {
		logic        two;
		logic [15:0] w0;
		logic [15:0] w1;
		logic [15:0] c0;
		logic [15:0] c1;
	} packet_t;

	localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
	localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
	localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
	localparam logic [20:0] SURR_FIRST       = 21'h00D800;
	localparam logic [20:0] SURR_LAST        = 21'h00DFFF;
	localparam logic [20:0] BMP_LAST         = 21'h00FFFF;
	localparam logic [20:0] SUPP_BASE        = 21'h010000;

endpackage

// ===== hdl/u8u16_decode.sv =====
// Byte decoder: next sequence state, word count and output packet for one byte.
// Depends on u8u16_pkg.
module u8u16_decode #(
	parameter int COUNT_WIDTH = 16
) (
	input  u8u16_pkg::in_item_t   item,
	input  u8u16_pkg::dec_state_t state_cur,
	input  logic [COUNT_WIDTH-1:0] count_cur,
	output u8u16_pkg::dec_state_t state_nxt,
	output logic [COUNT_WIDTH-1:0] count_nxt,
	output logic [1:0]             n_words,
	output u8u16_pkg::packet_t     pkt
);
	import u8u16_pkg::*;

	logic [20:0]            cp_shift;
	logic [20:0]            supp;
	logic [COUNT_WIDTH-1:0] count1;
	logic [COUNT_WIDTH-1:0] count2;
	logic [COUNT_WIDTH+15:0] ext1;
	logic [COUNT_WIDTH+15:0] ext2;
	dec_state_t             st;

	assign cp_shift = {state_cur.codepoint[14:0], item.byte_in[5:0]};
	assign supp     = cp_shift - SUPP_BASE;

	// saturating counts for first and second word
	assign count1 = (count_cur == '1) ? count_cur : count_cur + COUNT_WIDTH'(1);
	assign count2 = (count1 == '1) ? count1 : count1 + COUNT_WIDTH'(1);
	assign ext1   = {16'd0, count1};
	assign ext2   = {16'd0, count2};

	always_comb begin
		st      = '0;
		n_words = 2'd0;
		pkt.two = 1'b0;
		pkt.w0  = 16'd0;
		pkt.w1  = 16'd0;
		pkt.c0  = ext1[15:0];
		pkt.c1  = ext2[15:0];
		case (item.byte_in) inside
			[8'h00:8'h7F]: begin
				n_words = 2'd1;
				pkt.w0  = {8'd0, item.byte_in};
			end
			[8'h80:8'hBF]: begin
				if (state_cur.remaining != 2'd0) begin
					st.codepoint = cp_shift;
					st.remaining = state_cur.remaining - 2'd1;
					if (state_cur.remaining == 2'd1) begin
						if (cp_shift >= SURR_FIRST && cp_shift <= SURR_LAST) begin
							n_words = 2'd1;
							pkt.w0  = REPLACEMENT_CHAR;
						end else if (cp_shift <= BMP_LAST) begin
							n_words = 2'd1;
							pkt.w0  = cp_shift[15:0];
						end else begin
							n_words = 2'd2;
							pkt.two = 1'b1;
							pkt.w0  = HIGH_SURR_BASE | {5'd0, supp[20:10]};
							pkt.w1  = LOW_SURR_BASE | {6'd0, supp[9:0]};
						end
					end
				end
			end
			[8'hC0:8'hDF]: begin
				st.codepoint = {16'd0, item.byte_in[4:0]};
				st.remaining = 2'd1;
			end
			[8'hE0:8'hEF]: begin
				st.codepoint = {17'd0, item.byte_in[3:0]};
				st.remaining = 2'd2;
			end
			[8'hF0:8'hF7]: begin
				st.codepoint = {18'd0, item.byte_in[2:0]};
				st.remaining = 2'd3;
			end
			default: begin
				st = '0;
			end
		endcase
	end

	always_comb begin
		case (n_words)
			2'd1:    count_nxt = count1;
			2'd2:    count_nxt = count2;
			default: count_nxt = count_cur;
		endcase
		state_nxt = st;
		if (item.end_of_string) begin
			count_nxt = '0;
			state_nxt = '0;
		end
	end

endmodule

// ===== hdl/u8u16_queue.sv =====
// Two-packet output queue; streams one or two words per packet.
// Depends on u8u16_pkg.
module u8u16_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  u8u16_pkg::packet_t   pkt,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output u8u16_pkg::out_item_t out_data
);
	import u8u16_pkg::*;

	packet_t    head_q;
	packet_t    tail_q;
	logic [1:0] count_q;
	logic       sel_q;
	logic       take;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign room      = (count_q != 2'd2);
	assign take      = out_valid && out_ready;
	assign pop       = take && (!head_q.two || sel_q);

	assign out_data.word_out     = sel_q ? head_q.w1 : head_q.w0;
	assign out_data.last_of_run  = head_q.two ? sel_q : 1'b1;
	assign out_data.words_so_far = sel_q ? head_q.c1 : head_q.c0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			sel_q   <= 1'b0;
		end else begin
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
			if (pop)
				sel_q <= 1'b0;
			else if (take)
				sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && count_q == 2'd1)
				head_q <= pkt;
			else
				head_q <= tail_q;
			if (push && count_q == 2'd2)
				tail_q <= pkt;
		end else if (push) begin
			if (count_q == 2'd0)
				head_q <= pkt;
			else
				tail_q <= pkt;
		end
	end

endmodule

// ===== hdl/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 decoder, top level.
// Depends on u8u16_pkg, u8u16_decode and u8u16_queue.
//
// Takes one UTF-8 byte per cycle and returns UTF-16 words on a valid/ready
// output. A byte is registered, decoded in the next cycle and its words (none,
// one, or a surrogate pair) are pushed into a two-packet output queue when it
// has room; the first word is presented from the queue head after the push
// and can leave at the following edge. Bytes are taken every cycle while the
// queue has room; a surrogate pair leaves as two separate words, so a byte
// giving a pair costs more output bandwidth. Each word carries a saturating
// count of words so far in the string (COUNT_WIDTH bits, shown as the low
// 16); end_of_string clears the sequence and the count after its byte.
module utf8_to_utf16_decoder #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  u8u16_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output u8u16_pkg::out_item_t out_data
);
	import u8u16_pkg::*;

	logic                   valid_s1;
	in_item_t               data_s1;
	dec_state_t             state_q;
	logic [COUNT_WIDTH-1:0] count_q;
	dec_state_t             state_nxt;
	logic [COUNT_WIDTH-1:0] count_nxt;
	logic [1:0]             n_words;
	packet_t                pkt;
	logic                   room;
	logic                   advance;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || advance;

	u8u16_decode #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_decode (
		.item     (data_s1),
		.state_cur(state_q),
		.count_cur(count_q),
		.state_nxt(state_nxt),
		.count_nxt(count_nxt),
		.n_words  (n_words),
		.pkt      (pkt)
	);

	u8u16_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance && n_words != 2'd0),
		.pkt      (pkt),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
			count_q  <= '0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance) begin
				state_q <= state_nxt;
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			data_s1 <= in_data;
	end

endmodule

// ===== hdl/u8u16_checker.sv =====
// Port-level checks for the UTF-8 to UTF-16 decoder, bound to the top level.
// Depends on u8u16_pkg and utf8_to_utf16_decoder_assert.svh.
`include "utf8_to_utf16_decoder_assert.svh"

module u8u16_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input u8u16_pkg::in_item_t  in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input u8u16_pkg::out_item_t out_data
);
	import u8u16_pkg::*;

	`U8U16_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output item changed while stalled")

	// a high surrogate is always followed straight away by its low half
	`U8U16_ASSERT_NEXT(a_pair_follows, out_valid && out_ready && !out_data.last_of_run, out_valid && out_data.word_out[15:10] == 6'b110111, "low surrogate missing after high")

	`U8U16_ASSERT_ALWAYS(a_high_word, !(out_valid && !out_data.last_of_run) || out_data.word_out[15:11] == 5'b11011, "non-final word is not a high surrogate")

	`U8U16_ASSERT_NEXT(a_pair_count, out_valid && out_ready && !out_data.last_of_run, out_data.words_so_far == $past(out_data.words_so_far) + 16'd1 || out_data.words_so_far == $past(out_data.words_so_far), "word count did not step within a pair")

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (.*);

// ===== tb/utf16_word_checker.sv =====
// Checker for utf8_to_utf16_decoder: watches both channels, predicts the UTF-16 words
// and compares each accepted word with the oldest one predicted.
// Depends on u8u16_pkg.
module utf16_word_checker #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  u8u16_pkg::in_item_t  in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  u8u16_pkg::out_item_t out_data,
	output int                   mismatches,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import u8u16_pkg::*;

	logic [20:0]            cp_acc;
	logic [1:0]             conts_left;
	logic [COUNT_WIDTH-1:0] word_count;
	out_item_t              expected_words[$];
	int                     fail_count = 0;
	int                     pending_words = 0;

	assign mismatches  = fail_count;
	assign outstanding = pending_words;

	task automatic emit_word(input logic [15:0] w, input logic last);
		out_item_t e;
		if (word_count != '1)
			word_count++;
		e.word_out     = w;
		e.last_of_run  = last;
		e.words_so_far = 16'(word_count);
		expected_words.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [7:0]  b;
		logic [20:0] v;
		out_item_t   e;
		if (!arst_n) begin
			cp_acc     = '0;
			conts_left = '0;
			word_count = '0;
			expected_words.delete();
			pending_words <= 0;
		end else begin
			if (in_valid && in_ready) begin
				b = in_data.byte_in;
				if (b <= 8'h7F) begin
					cp_acc     = '0;
					conts_left = '0;
					emit_word({8'h00, b}, 1'b1);
				end else if (b <= 8'hBF && conts_left != 0) begin
					cp_acc     = {cp_acc[14:0], b[5:0]};
					conts_left = conts_left - 2'd1;
					if (conts_left == 0) begin
						if (cp_acc >= SURR_FIRST && cp_acc <= SURR_LAST) begin
							emit_word(REPLACEMENT_CHAR, 1'b1);
						end else if (cp_acc <= BMP_LAST) begin
							emit_word(cp_acc[15:0], 1'b1);
						end else begin
							// high word may exceed DBFF for code points past 10FFFF
							v = cp_acc - SUPP_BASE;
							emit_word(HIGH_SURR_BASE | 16'(v >> 10), 1'b0);
							emit_word(LOW_SURR_BASE | {6'd0, v[9:0]}, 1'b1);
						end
					end
				end else if (b >= 8'hC0 && b <= 8'hDF) begin
					cp_acc     = {16'd0, b[4:0]};
					conts_left = 2'd1;
				end else if (b >= 8'hE0 && b <= 8'hEF) begin
					cp_acc     = {17'd0, b[3:0]};
					conts_left = 2'd2;
				end else if (b >= 8'hF0 && b <= 8'hF7) begin
					cp_acc     = {18'd0, b[2:0]};
					conts_left = 2'd3;
				end else begin
					// stray continuation or F8-FF
					cp_acc     = '0;
					conts_left = '0;
				end
				if (in_data.end_of_string) begin
					cp_acc     = '0;
					conts_left = '0;
					word_count = '0;
				end
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					$error("unexpected word %h with nothing predicted", out_data.word_out);
				end else begin
					e = expected_words.pop_front();
					if (out_data.word_out !== e.word_out) begin
						fail_count++;
						$error("word_out: expected %h, got %h", e.word_out, out_data.word_out);
					end
					if (out_data.last_of_run !== e.last_of_run) begin
						fail_count++;
						$error("last_of_run: expected %b, got %b", e.last_of_run,
							out_data.last_of_run);
					end
					if (out_data.words_so_far !== e.words_so_far) begin
						fail_count++;
						$error("words_so_far: expected %0d, got %0d", e.words_so_far,
							out_data.words_so_far);
					end
				end
			end
			// nonblocking so the stimulus side reads a settled value after each edge
			pending_words <= expected_words.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Top of the utf8_to_utf16_decoder testbench: clock, reset, byte stimulus, output stalls
// and the verdict. Depends on u8u16_pkg, utf8_to_utf16_decoder and utf16_word_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import u8u16_pkg::*;

	localparam int COUNT_WIDTH    = 16;
	localparam int STALL_MAX      = 13;
	localparam int RANDOM_ITEMS   = 500;
	localparam int WATCHDOG_LIMIT = 500;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	bit steady = 1'b0;	// no idling on either side while set
	int mismatches;
	int outstanding;
	int quiet_cycles = 0;

	always #10 clk = ~clk;

	utf8_to_utf16_decoder #(.COUNT_WIDTH(COUNT_WIDTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	utf16_word_checker #(.COUNT_WIDTH(COUNT_WIDTH)) word_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	function automatic int unsigned draw_gap();
		return steady ? 0 : $urandom_range(0, STALL_MAX);
	endfunction

	// called at a rising edge; returns at the edge that accepts the item
	task automatic send_byte(input logic [7:0] b, input logic eos);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{byte_in: b, end_of_string: eos};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_words();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] lead_byte(input int unsigned conts);
		case (conts)
			1:       return 8'($urandom_range(8'hC0, 8'hDF));
			2:       return 8'($urandom_range(8'hE0, 8'hEF));
			default: return 8'($urandom_range(8'hF0, 8'hF7));
		endcase
	endfunction

	// one character, mostly well formed, sometimes broken or noise
	task automatic send_random_char(inout int unsigned bytes_sent);
		logic [7:0]  seq[$];
		int unsigned kind;
		int unsigned need;
		need = 0;
		kind = $urandom_range(0, 15);
		if (kind <= 3) begin
			seq.push_back(8'($urandom_range(0, 8'h7F)));
		end else if (kind <= 5) begin
			seq.push_back(lead_byte(1));
			need = 1;
		end else if (kind <= 7) begin
			seq.push_back(lead_byte(2));
			need = 2;
		end else if (kind == 8) begin
			// encoded surrogate
			seq.push_back(8'hED);
			seq.push_back(8'hA0 | 8'($urandom_range(0, 31)));
			need = 1;
		end else if (kind <= 10) begin
			seq.push_back(lead_byte(3));
			need = 3;
		end else if (kind == 11) begin
			seq.push_back(cont_byte());
		end else if (kind == 12) begin
			seq.push_back(8'($urandom_range(8'hF8, 8'hFF)));
		end else if (kind == 13) begin
			// truncated sequence
			need = $urandom_range(1, 3);
			seq.push_back(lead_byte(need));
			need = $urandom_range(0, need - 1);
		end else begin
			seq.push_back(8'($urandom_range(0, 255)));
		end
		repeat (need) seq.push_back(cont_byte());
		foreach (seq[i])
			send_byte(seq[i], $urandom_range(0, 23) == 0);
		bytes_sent += seq.size();
	endtask

	initial begin
		int unsigned stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("** utf8_to_utf16_decoder: FAILED **");
			$finish;
		end
	end

	initial begin
		int unsigned bytes_sent;
		bytes_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);
		// overlong NUL
		send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
		// surrogates D800 and DFFF become the replacement character
		send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'hED, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
		// U+10000 as a pair, then 1FFFFF beyond the Unicode range
		send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0);
		send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
		// stray continuation and invalid bytes
		send_byte(8'hBF, 1'b0); send_byte(8'hF8, 1'b0); send_byte(8'hFF, 1'b0);
		// new lead inside a sequence, then ASCII inside a sequence
		send_byte(8'hC3, 1'b0); send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
		send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);
		// unfinished at end of string
		send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b1);
		drain_words();

		while (bytes_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 39) == 0)
				steady = ~steady;
			send_random_char(bytes_sent);
			if ($urandom_range(0, 99) == 0)
				drain_words();
		end
		drain_words();

		// back to back: a pair closing a string, then a lone byte string
		steady = 1'b1;
		send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
		send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
		send_byte(8'h5A, 1'b1);
		steady = 1'b0;

		drain_words();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** utf8_to_utf16_decoder: PASSED **");
		else
			$display("** utf8_to_utf16_decoder: FAILED **");
		$finish;
	end

endmodule
